// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh - shared assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== src/khs_pkg.sv =====
// ----------------------------------------------------------------------------
// khs_pkg - key hash set package
// Field widths, status codes, probe constants and control structs.
// ----------------------------------------------------------------------------
package khs_pkg;

  localparam int KEY_W    = 64;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 12;
  localparam int COUNT_W  = 13;

  localparam logic [KEY_W-1:0] KEY_EMPTY = 64'd0;
  localparam logic [KEY_W-1:0] KEY_TOMB  = 64'd1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RESERVED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  localparam int unsigned PROBE_MUL  = 73;
  localparam int unsigned PROBE_STEP = 5009;

  localparam logic [COUNT_W-1:0] THRESH_RESET = 13'd3072;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic start;
    logic probe;
    logic clear;
    logic load_out;
  } khs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic reserved;
    logic hit;
    logic exhausted;
    logic clr_last;
  } khs_sts_t;

endpackage

// ===== src/khs_dpath.sv =====
// ----------------------------------------------------------------------------
// khs_dpath - key hash set datapath
// Slot memory, probe address generator, slot compare, counters, result regs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module khs_dpath import khs_pkg::*; #(
  parameter int TABLE_SLOTS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  khs_cmd_t            cmd,
  output khs_sts_t            sts,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_data,
  input  logic                op,
  input  logic [KEY_W-1:0]    key,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot_index,
  output logic [COUNT_W-1:0]  live_count,
  output logic [COUNT_W-1:0]  tombstone_count,
  output logic                needs_grow
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int SUM_W = (CNT_W + 1 > COUNT_W) ? CNT_W + 1 : COUNT_W;
  localparam logic [IDX_W-1:0] STEP     = IDX_W'(PROBE_STEP);
  localparam logic [CNT_W-1:0] ALL_SEEN = CNT_W'(TABLE_SLOTS);

  logic [KEY_W-1:0]    slot_mem [TABLE_SLOTS];
  logic [KEY_W-1:0]    rd_data;
  logic [KEY_W-1:0]    key_r;
  logic                op_r;
  logic                reserved_r;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    cmp_idx;
  logic [IDX_W-1:0]    clr_idx;
  logic [CNT_W-1:0]    visits;
  logic [CNT_W-1:0]    live_total;
  logic [CNT_W-1:0]    tomb_total;
  logic [COUNT_W-1:0]  threshold;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_slot;

  logic [IDX_W-1:0]    start_idx;
  logic                is_empty, is_tomb, is_eq, ins;
  logic                hit_write, hit_keep;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [KEY_W-1:0]    mem_wd;
  logic [SUM_W-1:0]    occ_sum;

  assign start_idx = IDX_W'(32'(key[IDX_W-1:0]) * PROBE_MUL);

  assign is_empty  = (rd_data == KEY_EMPTY);
  assign is_tomb   = (rd_data == KEY_TOMB);
  assign is_eq     = (rd_data == key_r);
  assign ins       = (op_r == OP_INSERT);
  assign hit_write = ins ? (is_empty || is_tomb) : is_eq;
  assign hit_keep  = ins ? is_eq : is_empty;

  assign sts.reserved  = reserved_r;
  assign sts.hit       = hit_write || hit_keep;
  assign sts.exhausted = (visits == ALL_SEEN);
  assign sts.clr_last  = (clr_idx == {IDX_W{1'b1}});

  assign mem_we = cmd.clear || (cmd.probe && hit_write);
  assign mem_wa = cmd.clear ? clr_idx : cmp_idx;
  assign mem_wd = cmd.clear ? KEY_EMPTY : (ins ? key_r : KEY_TOMB);

  assign occ_sum = SUM_W'(live_total) + SUM_W'(tomb_total);

  // one write port and one read port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    rd_data <= slot_mem[idx];
  end

  // control state: counters, threshold, clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      live_total <= '0;
      tomb_total <= '0;
      threshold  <= THRESH_RESET;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_data;
      end
      if (cmd.clear) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.probe && hit_write) begin
        if (ins) begin
          live_total <= live_total + 1'b1;
          if (is_tomb && tomb_total != '0) begin
            tomb_total <= tomb_total - 1'b1;
          end
        end else begin
          if (live_total != '0) begin
            live_total <= live_total - 1'b1;
          end
          tomb_total <= tomb_total + 1'b1;
        end
      end
    end
  end

  // payload: item, probe walk, result
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key_r      <= key;
      op_r       <= op;
      reserved_r <= (key == KEY_EMPTY) || (key == KEY_TOMB);
      idx        <= start_idx;
    end
    if (cmd.start) begin
      cmp_idx    <= idx;
      idx        <= idx + STEP;
      visits     <= CNT_W'(1);
      res_status <= ins ? ST_RESERVED : ST_NOT_FOUND;
      res_slot   <= '0;
    end
    if (cmd.probe) begin
      cmp_idx <= idx;
      idx     <= idx + STEP;
      visits  <= visits + 1'b1;
      if (hit_write) begin
        res_slot   <= cmp_idx;
        res_status <= ins ? ST_INSERTED : ST_REMOVED;
      end else if (hit_keep) begin
        res_status <= ins ? ST_DUPLICATE : ST_NOT_FOUND;
      end else if (sts.exhausted) begin
        res_status <= ST_FULL;
      end
    end
    if (cmd.load_out) begin
      status          <= res_status;
      slot_index      <= SLOT_W'(res_slot);
      live_count      <= COUNT_W'(live_total);
      tombstone_count <= COUNT_W'(tomb_total);
      needs_grow      <= (occ_sum >= SUM_W'(threshold));
    end
  end

  `ASSERT_NEVER(a_probe_past_end, clk, rst, cmd.probe && (visits > ALL_SEEN))
  `ASSERT_NEVER(a_write_while_clear, clk, rst, cmd.clear && cmd.probe)
  `ASSERT_AT(a_count_bound, clk, rst, occ_sum <= SUM_W'(TABLE_SLOTS))

endmodule

// ===== src/khs_ctrl.sv =====
// ----------------------------------------------------------------------------
// khs_ctrl - key hash set controller
// Sequences clear sweep, probe walk and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module khs_ctrl import khs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  khs_sts_t sts,
  output khs_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state, state_next;
  logic       out_free;
  logic       probe_stop;

  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);
  assign probe_stop = sts.hit || sts.exhausted;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_START;
        end
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = sts.reserved ? S_DONE : S_PROBE;
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (probe_stop) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_AT(a_accept_starts, clk, rst, (in_valid && in_ready) |=> (state == S_START))
  `ASSERT_AT(a_load_needs_room, clk, rst, cmd.load_out |-> out_free)
  `ASSERT_AT(a_probe_ends, clk, rst, (state == S_PROBE && probe_stop) |=> (state == S_DONE))

endmodule

// ===== src/key_hash_set_with_tombstones.sv =====
// ----------------------------------------------------------------------------
// key_hash_set_with_tombstones - open-addressing set of 64-bit keys
// Insert/remove with linear stepped probing, tombstones and load counters.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory to empty, one slot per cycle,
// and in_ready stays low until the sweep is done; the config port is open
// throughout. A word is taken and latched in the idle state; the start state
// issues the read of its first slot, and the probe state then compares one
// slot at a time until a slot settles the word or every slot is visited
// (status table full); reserved keys 0 and 1 skip the probe state. The done
// state loads the result and returns to idle, where the next word is taken.
// The pace is set by the single slot memory read port, one slot read per
// cycle, with the next address issued while the previous slot is compared.
// Probe start is (key * 73) mod TABLE_SLOTS, step 5009 mod TABLE_SLOTS;
// TABLE_SLOTS must be a power of two (16 to 65536). The result sits in an
// output register, so a new word is taken while the last result still waits
// for out_ready; the new word's own result then holds until that register
// is free. Counts wider than 13 bits and slots wider than 12 bits are
// truncated on the outputs; needs_grow compares the full counts with
// grow_threshold.

module key_hash_set_with_tombstones import khs_pkg::*; #(
  parameter int TABLE_SLOTS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  // configuration: grow_threshold
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [KEY_W-1:0]    key,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot_index,
  output logic [COUNT_W-1:0]  live_count,
  output logic [COUNT_W-1:0]  tombstone_count,
  output logic                needs_grow
);

  khs_cmd_t cmd;
  khs_sts_t sts;

  // threshold writes are always taken
  assign cfg_ready = 1'b1;

  khs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  khs_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid),
    .cfg_data        (cfg_data),
    .op              (op),
    .key             (key),
    .status          (status),
    .slot_index      (slot_index),
    .live_count      (live_count),
    .tombstone_count (tombstone_count),
    .needs_grow      (needs_grow)
  );

endmodule

// ===== tb/sv/key_hash_set_with_tombstones_tb.sv =====
// ----------------------------------------------------------------------------
// key_hash_set_with_tombstones_tb - self-checking bench for the key hash set
// Drives insert/remove words through the valid/ready ports, keeps a shadow
// copy of the slot table and its counters, and checks every result word,
// field by field, against the shadow's prediction. Covers reserved keys,
// probe chains with tombstones, threshold extremes and random traffic.
// ----------------------------------------------------------------------------
module key_hash_set_with_tombstones_tb;
  import khs_pkg::*;

  localparam int          TABLE_SLOTS = 4096;
  localparam int unsigned SLOT_MASK   = TABLE_SLOTS - 1;
  // cycles with no handshake on any port before the run is declared hung;
  // longer than a full-table probe or the reset sweep
  localparam int          QUIET_LIMIT = 30000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  live;
    logic [COUNT_W-1:0]  tomb;
    logic                grow;
  } op_outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                op = OP_INSERT;
  logic [KEY_W-1:0]    key = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [COUNT_W-1:0]  live_count;
  logic [COUNT_W-1:0]  tombstone_count;
  logic                needs_grow;

  // shadow of the block's state
  bit [KEY_W-1:0]     shadow_slots [TABLE_SLOTS];
  int unsigned        shadow_live;
  int unsigned        shadow_tomb;
  logic [COUNT_W-1:0] shadow_threshold = THRESH_RESET;

  op_outcome_t expected_outcomes [$];
  op_outcome_t due;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          in_gaps = 1'b1;     // sender idles between words
  bit          out_stalls = 1'b1;  // receiver drops out_ready at random
  int          ready_hold = 0;

  // single grow_threshold register; cfg_index 0 is implied by the port
  key_hash_set_with_tombstones #(.TABLE_SLOTS(TABLE_SLOTS)) DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .key             (key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .slot_index      (slot_index),
    .live_count      (live_count),
    .tombstone_count (tombstone_count),
    .needs_grow      (needs_grow)
  );

  always #5 clk = ~clk;

  // mostly no gap, often a short one, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Applies one word to the shadow table and returns the result it must give.
  // Insert stops at the first empty or tombstone slot, so a key sitting past a
  // tombstone in its chain gets a second copy; remove skips tombstones.
  function automatic op_outcome_t predict_outcome(input logic word_op,
                                                  input logic [KEY_W-1:0] word_key);
    op_outcome_t    r;
    logic [KEY_W-1:0] prod;
    logic [KEY_W-1:0] v;
    int unsigned    idx;
    int unsigned    n;
    bit             done;
    r = '0;
    if (word_key == KEY_EMPTY || word_key == KEY_TOMB) begin
      r.status = (word_op == OP_INSERT) ? ST_RESERVED : ST_NOT_FOUND;
    end else begin
      prod = word_key * KEY_W'(PROBE_MUL);
      idx  = prod[31:0] & SLOT_MASK;
      r.status = ST_FULL;  // stands if every slot is visited
      done = 1'b0;
      for (n = 0; n < TABLE_SLOTS && !done; n++) begin
        v = shadow_slots[idx];
        if (word_op == OP_INSERT) begin
          if (v == KEY_EMPTY || v == KEY_TOMB) begin
            if (v == KEY_TOMB && shadow_tomb > 0) shadow_tomb--;
            shadow_slots[idx] = word_key;
            shadow_live++;
            r.status = ST_INSERTED;
            r.slot   = SLOT_W'(idx);
            done     = 1'b1;
          end else if (v == word_key) begin
            r.status = ST_DUPLICATE;
            done     = 1'b1;
          end
        end else begin
          if (v == KEY_EMPTY) begin
            r.status = ST_NOT_FOUND;
            done     = 1'b1;
          end else if (v == word_key) begin
            shadow_slots[idx] = KEY_TOMB;
            if (shadow_live > 0) shadow_live--;
            shadow_tomb++;
            r.status = ST_REMOVED;
            r.slot   = SLOT_W'(idx);
            done     = 1'b1;
          end
        end
        idx = (idx + PROBE_STEP) & SLOT_MASK;
      end
    end
    r.live = COUNT_W'(shadow_live);
    r.tomb = COUNT_W'(shadow_tomb);
    r.grow = (shadow_live + shadow_tomb) >= shadow_threshold;
    return r;
  endfunction

  // Sends one word; the prediction is taken at the accepting edge.
  task automatic send_word(input logic word_op, input logic [KEY_W-1:0] word_key);
    int pause;
    in_valid <= 1'b1;
    op       <= word_op;
    key      <= word_key;
    do @(posedge clk); while (!in_ready);
    expected_outcomes.push_back(predict_outcome(word_op, word_key));
    pause = in_gaps ? gap_len() : 0;
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  // Sender pauses until every outstanding result word has come back.
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // Only called with nothing in flight.
  task automatic write_threshold(input logic [COUNT_W-1:0] level);
    cfg_valid <= 1'b1;
    cfg_data  <= level;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_threshold = level;
  endtask

  // ---------------------------------------------------------------- tests --

  // Keys 0 and 1 mark empty and tombstone slots: insert is rejected, remove
  // must report not found rather than match a tombstone.
  task automatic test_reserved_keys();
    send_word(OP_INSERT, KEY_EMPTY);
    send_word(OP_INSERT, KEY_TOMB);
    send_word(OP_REMOVE, KEY_EMPTY);
    send_word(OP_REMOVE, KEY_TOMB);
    wait_idle();
  endtask

  task automatic test_key_extremes();
    send_word(OP_INSERT, '1);
    send_word(OP_INSERT, '1);  // duplicate
    send_word(OP_REMOVE, '1);
    send_word(OP_REMOVE, '1);  // only a tombstone left in the chain
    send_word(OP_INSERT, 64'h8000_0000_0000_0000);
    send_word(OP_INSERT, 64'h2);
    wait_idle();
  endtask

  // Three keys that share a start slot (equal low 12 bits) form one chain.
  task automatic test_tombstone_chain();
    logic [KEY_W-1:0] ka, kb, kc;
    ka = 64'h0000_0000_0000_0ABC;
    kb = ka + 64'h1000;
    kc = ka + 64'h2000;
    send_word(OP_INSERT, ka);
    send_word(OP_INSERT, kb);
    send_word(OP_INSERT, kc);
    send_word(OP_REMOVE, ka);  // head of chain becomes a tombstone
    send_word(OP_REMOVE, ka);  // walks past tombstone and both keys
    send_word(OP_INSERT, kc);  // lands on the tombstone: second copy
    send_word(OP_REMOVE, kc);  // takes the first copy
    send_word(OP_REMOVE, kb);
    send_word(OP_INSERT, kb);  // reuses the head tombstone
    wait_idle();
  endtask

  // Zero keeps needs_grow raised; 4095 and 4096 cover every data bit.
  task automatic test_threshold_extremes();
    write_threshold('0);
    send_word(OP_INSERT, rand_key());
    wait_idle();
    write_threshold(COUNT_W'(4095));
    send_word(OP_REMOVE, KEY_TOMB);
    wait_idle();
    write_threshold(COUNT_W'(4096));
    send_word(OP_REMOVE, KEY_TOMB);
    wait_idle();
  endtask

  // Keys are drawn mostly from a pool whose members share a handful of start
  // slots, so chains grow long and tombstones sit inside them.
  task automatic test_random_traffic();
    logic [KEY_W-1:0] pool [48];
    logic [11:0]      chain_base [6];
    int               phase, i, r;
    for (i = 0; i < 6; i++) chain_base[i] = 12'($urandom);
    for (i = 0; i < 48; i++) pool[i] = {52'(rand_key() >> 12), chain_base[i % 6]};
    for (phase = 0; phase < 3; phase++) begin
      // middle phase runs with no idling on either side
      in_gaps    = (phase != 1);
      out_stalls = (phase != 1);
      write_threshold(COUNT_W'($urandom_range(0, 120)));
      for (i = 0; i < 250; i++) begin
        r = $urandom_range(0, 99);
        if (r < 52)
          send_word(OP_INSERT, pool[$urandom_range(0, 47)]);
        else if (r < 88)
          send_word(OP_REMOVE, pool[$urandom_range(0, 47)]);
        else if (r < 94)
          send_word(1'($urandom_range(0, 1)), rand_key());
        else
          send_word(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 1)));
      end
      wait_idle();
    end
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
  endtask

  // --------------------------------------------------------------- result --

  // receiver: runs of ready broken by stalls of random length
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!out_stalls || $urandom_range(0, 2) != 0) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 10);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= gap_len();
    end
  end

  // each accepted result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        $error("result word with none expected: status %0d slot %0d", status, slot_index);
        mismatches++;
      end else begin
        due = expected_outcomes.pop_front();
        if (status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, status);
          mismatches++;
        end
        if (slot_index !== due.slot) begin
          $error("slot_index: expected %0d, got %0d", due.slot, slot_index);
          mismatches++;
        end
        if (live_count !== due.live) begin
          $error("live_count: expected %0d, got %0d", due.live, live_count);
          mismatches++;
        end
        if (tombstone_count !== due.tomb) begin
          $error("tombstone_count: expected %0d, got %0d", due.tomb, tombstone_count);
          mismatches++;
        end
        if (needs_grow !== due.grow) begin
          $error("needs_grow: expected %0d, got %0d", due.grow, needs_grow);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without a handshake on any port means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // first words wait out the post-reset sweep on in_ready;
    // threshold still at its reset value here
    test_reserved_keys();
    test_key_extremes();
    test_tombstone_chain();
    test_threshold_extremes();
    test_random_traffic();
    wait_idle();
    repeat (20) @(posedge clk);  // catch any stray result word
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
